>>> rtl/core/assert_macros.svh
// assertion macros shared by the envelope rtl
// each macro expects signals named clk and rst in the enclosing module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checks off during reset
`define AST_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checks off during reset
`define AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/ade_pkg.sv
// shared types, constants and the control store of the envelope generator
// no dependencies
package ade_pkg;

  // field and register widths
  localparam int REG_W   = 24;             // attack/decay length registers
  localparam int OPW     = REG_W + 1;      // divider operand width, holds a + d
  localparam int REMW    = OPW + 1;        // divider partial remainder
  localparam int Q_W     = 16;             // level and phase words
  localparam int FRAC_W  = 15;             // decay base q, Q0.15
  localparam int SQ_W    = 2 * FRAC_W;     // q squared
  localparam int CUBE_W  = 3 * FRAC_W;     // q cubed
  localparam int DIV_STEPS = 16;           // quotient bits per division
  localparam int DCNT_W  = $clog2(DIV_STEPS + 1);

  localparam int COUNT_WIDTH_DEFAULT = 24;

  localparam logic [REG_W-1:0] ATTACK_RESET = REG_W'(480);
  localparam logic [REG_W-1:0] DECAY_RESET  = REG_W'(24000);
  localparam logic [Q_W-1:0]   Q_ONE        = 16'h8000;
  localparam logic [14:0]      TRIG_LEVEL   = 15'd16384;

  // register indexes
  localparam logic CFG_ATTACK = 1'b0;
  localparam logic CFG_DECAY  = 1'b1;

  // envelope stage codes
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ATTACK = 2'd1;
  localparam logic [1:0] ST_DECAY  = 2'd2;

  // what remains to compute for the current word
  typedef enum logic [1:0] {
    M_NONE    = 2'd0,  // level and phase already final
    M_ATK_END = 2'd1,  // level is full scale, phase still needed
    M_ATK     = 2'd2,  // attack ramp
    M_DEC     = 2'd3   // decay curve
  } mode_t;

  typedef enum logic [3:0] {
    U_NOP         = 4'd0,
    U_ACCEPT      = 4'd1,
    U_DIV_PHASE   = 4'd2,
    U_DIV_STEP    = 4'd3,
    U_PHASE_STORE = 4'd4,
    U_DIV_LEVEL   = 4'd5,
    U_LEVEL_STORE = 4'd6,
    U_MUL_SQ      = 4'd7,
    U_MUL_CUBE    = 4'd8,
    U_CUBE_STORE  = 4'd9,
    U_OUT         = 4'd10
  } uop_t;

  typedef enum logic [2:0] {
    C_NEVER       = 3'd0,
    C_ALWAYS      = 3'd1,
    C_NO_ITEM     = 3'd2,
    C_MODE_NONE   = 3'd3,
    C_DIV_MORE    = 3'd4,
    C_MODE_ATK_END = 3'd5,
    C_MODE_ATK    = 3'd6,
    C_OUT_BLOCKED = 3'd7
  } cond_t;

  typedef logic [3:0] pc_t;

  typedef struct packed {
    uop_t  op;
    cond_t cond;
    pc_t   target;
  } ctrl_t;

  // program labels
  localparam pc_t PC_ACC = 4'd0;
  localparam pc_t PC_BR  = 4'd1;
  localparam pc_t PC_PHL = 4'd2;
  localparam pc_t PC_PHR = 4'd3;
  localparam pc_t PC_PHS = 4'd4;
  localparam pc_t PC_LVL = 4'd5;
  localparam pc_t PC_LVR = 4'd6;
  localparam pc_t PC_LVS = 4'd7;
  localparam pc_t PC_MSQ = 4'd8;
  localparam pc_t PC_MCU = 4'd9;
  localparam pc_t PC_CUS = 4'd10;
  localparam pc_t PC_OUT = 4'd11;
  localparam pc_t PC_JMP = 4'd12;

  // control store
  function automatic ctrl_t ucode(input pc_t pc);
    ctrl_t cw;
    case (pc)
      PC_ACC: cw = '{U_ACCEPT,      C_NO_ITEM,      PC_ACC};
      PC_BR:  cw = '{U_NOP,         C_MODE_NONE,    PC_OUT};
      PC_PHL: cw = '{U_DIV_PHASE,   C_NEVER,        PC_ACC};
      PC_PHR: cw = '{U_DIV_STEP,    C_DIV_MORE,     PC_PHR};
      PC_PHS: cw = '{U_PHASE_STORE, C_MODE_ATK_END, PC_OUT};
      PC_LVL: cw = '{U_DIV_LEVEL,   C_NEVER,        PC_ACC};
      PC_LVR: cw = '{U_DIV_STEP,    C_DIV_MORE,     PC_LVR};
      PC_LVS: cw = '{U_LEVEL_STORE, C_MODE_ATK,     PC_OUT};
      PC_MSQ: cw = '{U_MUL_SQ,      C_NEVER,        PC_ACC};
      PC_MCU: cw = '{U_MUL_CUBE,    C_NEVER,        PC_ACC};
      PC_CUS: cw = '{U_CUBE_STORE,  C_NEVER,        PC_ACC};
      PC_OUT: cw = '{U_OUT,         C_OUT_BLOCKED,  PC_OUT};
      PC_JMP: cw = '{U_NOP,         C_ALWAYS,       PC_ACC};
      default: cw = '{U_NOP,        C_ALWAYS,       PC_ACC};
    endcase
    return cw;
  endfunction

endpackage

>>> rtl/core/attack_decay_envelope.sv
// attack-decay envelope generator, microcoded sequencer over a shared
// radix-2 divider and a 30x15 multiplier; uses ade_pkg and assert_macros.svh
//
//  channel   direction  signals                              width
//  input     in         in_valid, in_stall, trigger_sample   16 signed
//  output    out        out_valid, out_stall, envelope_level,
//                       envelope_phase                       16 + 16 unsigned
//  config    in         cfg_write, cfg_index, cfg_data       1 + 24
//
// work per word: nothing when idle or at the end of decay, a phase division
// at the end of attack, phase then level division during attack, and these
// plus q^2 and q^3 during decay; the divisions are 16-step, on the one divider
// in_stall is low only while the sequencer sits on its accept step
// a finished word waits in the output register; the next word is taken
// only after it has been loaded there
// rst is synchronous: stage, counter, trigger history, sequencer and
// registers return to their defaults (attack 480, decay 24000)
`include "assert_macros.svh"

module attack_decay_envelope
  import ade_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  // trigger input
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [Q_W-1:0]  trigger_sample,
  // envelope output
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [Q_W-1:0]         envelope_level,
  output logic [Q_W-1:0]         envelope_phase,
  // configuration
  input  logic                   cfg_write,
  input  logic                   cfg_index,
  input  logic [REG_W-1:0]       cfg_data
);

  // compare width wide enough for both the counter and the operands
  localparam int WIDE = (COUNT_WIDTH > OPW) ? COUNT_WIDTH : OPW;
  // largest count the divider operands can carry
  localparam logic [WIDE-1:0] N_CLAMP = WIDE'({OPW{1'b1}});

  // configuration registers
  logic [REG_W-1:0] attack_samples;
  logic [REG_W-1:0] decay_samples;

  // envelope state
  logic [1:0]             stage;
  logic [COUNT_WIDTH-1:0] elapsed_count;
  logic                   trigger_was_high;

  // sequencer
  pc_t   pc;
  pc_t   pc_next;
  ctrl_t cw;
  logic  take;
  mode_t mode;

  // datapath
  logic [OPW-1:0]    n_work;      // count value used for this word
  logic [Q_W-1:0]    level;
  logic [Q_W-1:0]    phase;
  logic [REMW-1:0]   rem;
  logic [OPW-1:0]    den;
  logic [Q_W-1:0]    quo;
  logic [DCNT_W-1:0] div_cnt;
  logic [FRAC_W-1:0] qbase;
  logic [CUBE_W-1:0] prod;

  // combinational helpers
  logic                   in_accept;
  logic                   high;
  logic                   rise;
  logic [1:0]             st0;
  logic [COUNT_WIDTH-1:0] n0;
  logic [COUNT_WIDTH-1:0] n1;
  logic                   counting;
  logic [WIDE-1:0]        n1_wide;
  logic                   ge_a;
  logic                   ge_d;
  logic [OPW-1:0]         total;
  logic [OPW-1:0]         ph_num;
  logic [OPW-1:0]         lv_num;
  logic [OPW-1:0]         lv_den;
  logic [REMW-1:0]        trial;
  logic                   qbit;
  logic [SQ_W-1:0]        mul_a;
  logic [CUBE_W-1:0]      mul_p;
  logic                   out_load;

  assign cw        = ucode(pc);
  assign in_stall  = (pc != PC_ACC);
  assign in_accept = in_valid && !in_stall;

  // trigger edge and stage advance for the incoming word
  assign high     = !trigger_sample[Q_W-1] && (trigger_sample[Q_W-2:0] > TRIG_LEVEL);
  assign rise     = high && !trigger_was_high;
  assign st0      = rise ? ST_ATTACK : stage;
  assign n0       = rise ? '0 : elapsed_count;
  assign counting = (st0 == ST_ATTACK) || (st0 == ST_DECAY);
  // counter saturates at all ones
  assign n1       = (counting && (n0 != '1)) ? n0 + 1'b1 : n0;
  assign n1_wide  = WIDE'(n1);
  assign ge_a     = n1_wide >= WIDE'(attack_samples);
  assign ge_d     = n1_wide >= WIDE'(decay_samples);

  // divider operands
  assign total  = {1'b0, attack_samples} + {1'b0, decay_samples};
  assign ph_num = (mode == M_DEC) ? {1'b0, attack_samples} + n_work : n_work;
  assign lv_num = (mode == M_DEC) ? {1'b0, decay_samples} - n_work : n_work;
  assign lv_den = (mode == M_DEC) ? {1'b0, decay_samples} : {1'b0, attack_samples};

  // restoring step; first step compares the dividend unshifted
  assign trial = (div_cnt == DCNT_W'(DIV_STEPS)) ? rem : {rem[REMW-2:0], 1'b0};
  assign qbit  = trial >= {1'b0, den};

  // shared multiplier: q*q, then q^2*q
  assign mul_a = (cw.op == U_MUL_CUBE) ? prod[SQ_W-1:0] : SQ_W'(qbase);
  assign mul_p = {{FRAC_W{1'b0}}, mul_a} * {{SQ_W{1'b0}}, qbase};

  // output register loads when empty or being drained
  assign out_load = (cw.op == U_OUT) && !(out_valid && out_stall);

  // branch condition
  always_comb begin
    case (cw.cond)
      C_NEVER:        take = 1'b0;
      C_ALWAYS:       take = 1'b1;
      C_NO_ITEM:      take = !in_accept;
      C_MODE_NONE:    take = (mode == M_NONE);
      C_DIV_MORE:     take = (div_cnt > DCNT_W'(1));
      C_MODE_ATK_END: take = (mode == M_ATK_END);
      C_MODE_ATK:     take = (mode == M_ATK);
      C_OUT_BLOCKED:  take = out_valid && out_stall;
      default:        take = 1'b0;
    endcase
    pc_next = take ? cw.target : pc + 1'b1;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      attack_samples <= ATTACK_RESET;
      decay_samples  <= DECAY_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ATTACK: attack_samples <= cfg_data;
        CFG_DECAY:  decay_samples  <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer, envelope state and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      pc               <= PC_ACC;
      stage            <= ST_IDLE;
      elapsed_count    <= '0;
      trigger_was_high <= 1'b0;
      mode             <= M_NONE;
      out_valid        <= 1'b0;
    end else begin
      pc <= pc_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if ((cw.op == U_ACCEPT) && in_accept) begin
        trigger_was_high <= high;
        case (st0)
          ST_ATTACK: begin
            if (ge_a) begin
              mode          <= M_ATK_END;
              stage         <= ST_DECAY;
              elapsed_count <= '0;
            end else begin
              mode          <= M_ATK;
              stage         <= ST_ATTACK;
              elapsed_count <= n1;
            end
          end
          ST_DECAY: begin
            mode          <= ge_d ? M_NONE : M_DEC;
            stage         <= ge_d ? ST_IDLE : ST_DECAY;
            elapsed_count <= n1;
          end
          default: begin
            mode <= M_NONE;
          end
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (cw.op)
      U_ACCEPT: begin
        if (in_accept) begin
          // a count past the operand range still reads as full progress
          n_work <= (n1_wide > N_CLAMP) ? '1 : n1_wide[OPW-1:0];
          if ((st0 == ST_ATTACK) && ge_a) begin
            level <= Q_ONE;
          end else if (!((st0 == ST_ATTACK) || ((st0 == ST_DECAY) && !ge_d))) begin
            // idle or end of decay
            level <= '0;
            phase <= '0;
          end
        end
      end
      U_DIV_PHASE: begin
        rem     <= {1'b0, ph_num};
        den     <= total;
        div_cnt <= DCNT_W'(DIV_STEPS);
      end
      U_DIV_LEVEL: begin
        rem     <= {1'b0, lv_num};
        den     <= lv_den;
        div_cnt <= DCNT_W'(DIV_STEPS);
      end
      U_DIV_STEP: begin
        rem     <= qbit ? trial - {1'b0, den} : trial;
        quo     <= {quo[Q_W-2:0], qbit};
        div_cnt <= div_cnt - 1'b1;
      end
      U_PHASE_STORE: begin
        // progress at or past the full length, zero total included, is full scale
        phase <= (ph_num >= total) ? Q_ONE : quo;
      end
      U_LEVEL_STORE: begin
        level <= quo;
        qbase <= quo[FRAC_W-1:0];
      end
      U_MUL_SQ, U_MUL_CUBE: begin
        prod <= mul_p;
      end
      U_CUBE_STORE: begin
        level <= {1'b0, prod[CUBE_W-1:SQ_W]};
      end
      U_OUT: begin
        if (out_load) begin
          envelope_level <= level;
          envelope_phase <= phase;
        end
      end
      default: ;
    endcase
  end

  `AST_NEXT(a_one_word_at_a_time, in_accept, in_stall, "input taken while a word is in flight")
  `AST_IMPL(a_out_in_range, out_valid,
    (envelope_level <= Q_ONE) && (envelope_phase <= Q_ONE), "output above full scale")
  `AST_IMPL(a_idle_gives_zero, (pc == PC_OUT) && (mode == M_NONE),
    (level == '0) && (phase == '0), "idle word not zero")
  `AST_IMPL(a_div_count_live, cw.op == U_DIV_STEP,
    (div_cnt != '0) && (div_cnt <= DCNT_W'(DIV_STEPS)), "divider stepped out of range")

endmodule

>>> dv/attack_decay_envelope_tb.sv
// self-checking testbench for attack_decay_envelope: directed and random trigger words,
// word-by-word envelope prediction, field-by-field compare of every output word
// depends on ade_pkg and the envelope rtl only
`timescale 1ns / 1ps

module attack_decay_envelope_tb
  import ade_pkg::*;
();

  localparam int CNT_W = COUNT_WIDTH_DEFAULT;
  localparam logic [REG_W-1:0] LEN_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_SAT = '1;
  localparam int PHASES = 10;
  localparam int WORDS_PER_PHASE = 115;

  typedef struct packed {
    logic [Q_W-1:0] level;
    logic [Q_W-1:0] phase;
  } envelope_word_t;

  // dut ports, all inputs known from time zero
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic signed [Q_W-1:0] trigger_sample = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [Q_W-1:0]        envelope_level;
  logic [Q_W-1:0]        envelope_phase;
  logic                  cfg_write = 1'b0;
  logic                  cfg_index = CFG_ATTACK;
  logic [REG_W-1:0]      cfg_data = '0;

  // trigger words waiting to be sent, envelope words waiting to come back
  logic signed [Q_W-1:0] trigger_queue[$];
  envelope_word_t        expected_words[$];
  int                    error_count = 0;

  // idling percentages for the current phase
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // predictor copy of the envelope state and the two length registers
  logic [1:0]       env_stage;
  logic [CNT_W-1:0] env_count;
  logic             env_trig_prev;
  logic [REG_W-1:0] atk_len;
  logic [REG_W-1:0] dec_len;

  attack_decay_envelope dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .trigger_sample (trigger_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .envelope_level (envelope_level),
    .envelope_phase (envelope_phase),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // floor(num * 2^15 / den), saturated at full scale; full scale when den is zero
  function automatic logic [Q_W-1:0] q15_ratio(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] r;
    if (den == 0) return Q_ONE;
    r = (num << 15) / den;
    return (r > 64'(Q_ONE)) ? Q_ONE : r[Q_W-1:0];
  endfunction

  // advance the envelope by one trigger word and queue the word it produces
  task automatic step_envelope(input logic signed [Q_W-1:0] trig);
    logic           high;
    logic [63:0]    a;
    logic [63:0]    d;
    logic [63:0]    total;
    logic [63:0]    q;
    logic [63:0]    lvl;
    logic [Q_W-1:0] ph;
    a = 64'(atk_len);
    d = 64'(dec_len);
    total = a + d;
    lvl = 0;
    ph = '0;
    // high only for positive values strictly above one half
    high = !trig[Q_W-1] && (trig[14:0] > TRIG_LEVEL);
    // rising crossing restarts the attack, even mid-envelope
    if (high && !env_trig_prev) begin
      env_stage = ST_ATTACK;
      env_count = '0;
    end
    env_trig_prev = high;
    case (env_stage)
      ST_ATTACK: begin
        if (env_count != CNT_SAT) env_count = env_count + 1'b1;
        ph = q15_ratio(64'(env_count), total);
        // zero attack length lands here on the first tick
        if (64'(env_count) >= a) begin
          lvl = 64'(Q_ONE);
          env_stage = ST_DECAY;
          env_count = '0;
        end else begin
          lvl = (64'(env_count) << 15) / a;
        end
      end
      ST_DECAY: begin
        if (env_count != CNT_SAT) env_count = env_count + 1'b1;
        if (64'(env_count) >= d) begin
          // end of decay, also the zero decay case: word is all zero
          env_stage = ST_IDLE;
        end else begin
          q = ((d - 64'(env_count)) << 15) / d;
          lvl = (q * q * q) >> 30;
          if (lvl > 64'(Q_ONE)) lvl = 64'(Q_ONE);
          ph = q15_ratio(a + 64'(env_count), total);
        end
      end
      default: begin
        // idle, and the unused stage code behaves the same
      end
    endcase
    expected_words.push_back('{level: lvl[Q_W-1:0], phase: ph});
  endtask

  // driver: hold a word until accepted, then maybe idle, then offer the next one
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      trigger_sample <= '0;
      env_stage = ST_IDLE;
      env_count = '0;
      env_trig_prev = 1'b0;
      atk_len = ATTACK_RESET;
      dec_len = DECAY_RESET;
    end else begin
      // track register writes in the predictor at the same edge the dut takes them
      if (cfg_write) begin
        if (cfg_index == CFG_ATTACK) atk_len = cfg_data;
        else dec_len = cfg_data;
      end
      if (!in_valid || !in_stall) begin
        if (in_valid) step_envelope(trigger_sample);
        if (trigger_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          trigger_sample <= trigger_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each accepted word with the oldest prediction, stall at random
  always @(posedge clk) begin : monitor
    envelope_word_t w;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("unexpected envelope word: level %0d phase %0d", envelope_level,
                 envelope_phase);
          error_count++;
        end else begin
          w = expected_words.pop_front();
          if (envelope_level !== w.level) begin
            $error("envelope_level expected %0d got %0d", w.level, envelope_level);
            error_count++;
          end
          if (envelope_phase !== w.phase) begin
            $error("envelope_phase expected %0d got %0d", w.phase, envelope_phase);
            error_count++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // register write, one clock wide
  task automatic write_length(input logic idx, input logic [REG_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // wait until every queued word went in and every predicted word came out
  task automatic wait_quiet();
    do @(posedge clk);
    while (trigger_queue.size() != 0 || in_valid || expected_words.size() != 0);
    // last word loaded, let the sequencer get back to its accept step
    repeat (8) @(posedge clk);
  endtask

  // 0 none, 1 sender idles, 2 receiver stalls, 3 both lightly
  task automatic set_idling(input int mode);
    case (mode)
      1: begin send_idle_pct <= 55; recv_stall_pct <= 0; end
      2: begin send_idle_pct <= 0; recv_stall_pct <= 55; end
      3: begin send_idle_pct <= 7; recv_stall_pct <= 7; end
      default: begin send_idle_pct <= 0; recv_stall_pct <= 0; end
    endcase
  endtask

  // mostly clean gate patterns (short high run, low run long enough for the
  // envelope to play out or get cut by a retrigger) plus bursts of raw noise
  task automatic add_random_triggers(input int n, input int span);
    int added;
    int run;
    int r;
    logic [Q_W-1:0] v;
    added = 0;
    while (added < n) begin
      r = $urandom_range(0, 9);
      if (r < 8) begin
        run = $urandom_range(1, 3);
        repeat (run) begin
          v = 16'($urandom_range(16385, 32767));
          trigger_queue.push_back(v);
          added++;
        end
        // r == 0 gives a quick retrigger in the middle of the envelope
        run = (r == 0) ? $urandom_range(1, 3) : $urandom_range(1, span);
        repeat (run) begin
          v = 16'($urandom);
          if (!v[15] && v[14:0] > TRIG_LEVEL) v[14] = 1'b0;
          trigger_queue.push_back(v);
          added++;
        end
      end else begin
        run = $urandom_range(1, 4);
        repeat (run) begin
          trigger_queue.push_back(16'($urandom));
          added++;
        end
      end
    end
  endtask

  // length settings for the random phases, extremes included
  logic [REG_W-1:0] atk_plan[PHASES] = '{3, 0, 12, 1, 0, 20, LEN_MAX, 7, 480, 5};
  logic [REG_W-1:0] dec_plan[PHASES] = '{5, 7, 0, 1, 0, 33, 4, LEN_MAX, 24000, 2};

  initial begin : stimulus
    int span;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset lengths: first word high starts the attack at once, then the
    // threshold edges (one half is not high, one step above is), both extremes
    trigger_queue = '{16'sh7FFF, 16'sh4000, -16'sh8000, 16'sh4001, 16'sh0000,
                      16'sh7FFF, -16'sh0001, 16'sh4000};
    wait_quiet();

    // zero attack: full scale on the first tick, then a short decay and a retrigger
    write_length(CFG_ATTACK, '0);
    write_length(CFG_DECAY, 24'd3);
    set_idling(3);
    trigger_queue = '{16'sh7FFF, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,
                      16'sh5000, 16'sh0000};
    wait_quiet();

    // zero decay: the decay tick gives an all-zero word
    write_length(CFG_ATTACK, 24'd2);
    write_length(CFG_DECAY, '0);
    trigger_queue = '{16'sh6000, 16'sh1000, 16'sh1000, 16'sh1000};
    wait_quiet();

    // zero total length: phase is full scale while active
    write_length(CFG_ATTACK, '0);
    trigger_queue = '{16'sh7FFF, 16'sh0000, 16'sh0000};
    wait_quiet();

    // longest lengths: tiny level steps, phase far from full scale
    write_length(CFG_ATTACK, LEN_MAX);
    write_length(CFG_DECAY, LEN_MAX);
    trigger_queue = '{16'sh7FFF, 16'sh7FFF, 16'sh0000};
    wait_quiet();

    // random phases, idling pattern rotates so every mode sees several settings
    atk_plan[PHASES-1] = 24'($urandom_range(0, 30));
    dec_plan[PHASES-1] = 24'($urandom_range(0, 30));
    for (int p = 0; p < PHASES; p++) begin
      write_length(CFG_ATTACK, atk_plan[p]);
      write_length(CFG_DECAY, dec_plan[p]);
      set_idling(p % 4);
      span = int'(atk_plan[p]) + int'(dec_plan[p]) + 6;
      if (span > 60 || span < 0) span = 60;
      add_random_triggers(WORDS_PER_PHASE, span);
      wait_quiet();
    end

    // drain: time for any stray output to show up
    set_idling(0);
    repeat (100) @(posedge clk);
    if (expected_words.size() != 0) begin
      $error("%0d envelope words never arrived", expected_words.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin : watchdog
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/ade_pkg.sv
rtl/core/attack_decay_envelope.sv
dv/attack_decay_envelope_tb.sv
